@@ design/bthpo_pkg.sv @@
// Shared types, constants and object length table for the object parser.
// No dependencies.
package bthpo_pkg;

  localparam int MAX_PACKET_BYTES_DEFAULT = 255;
  localparam int QUEUE_DEPTH = 2;
  localparam int OBJ_TABLE_SIZE = 102;

  localparam logic [2:0] HDR_VERSION = 3'd2;
  localparam logic [7:0] ADDR_END_POS = 8'd6;
  localparam logic [7:0] ENC_MIN_POS = 8'd9;
  localparam logic [7:0] POS_MAX = 8'd255;
  localparam logic [8:0] TEXT_LEN_DUE = 9'h100;
  localparam logic signed [19:0] ZERO_KELVIN_CENTI = -20'sd27315;
  localparam logic [6:0] BATTERY_MAX = 7'd100;
  localparam logic signed [1:0] LOW_FLAG_NONE = -2'sd1;

  localparam logic [7:0] OBJ_BATTERY      = 8'h01;
  localparam logic [7:0] OBJ_TEMP         = 8'h02;
  localparam logic [7:0] OBJ_HUMIDITY     = 8'h03;
  localparam logic [7:0] OBJ_PRESSURE     = 8'h04;
  localparam logic [7:0] OBJ_VOLTAGE      = 8'h0C;
  localparam logic [7:0] OBJ_LOW_BATT     = 8'h15;
  localparam logic [7:0] OBJ_HUMIDITY_PCT = 8'h2E;
  localparam logic [7:0] OBJ_TEMP_DECI    = 8'h45;
  localparam logic [7:0] OBJ_TEXT         = 8'h53;
  localparam logic [7:0] OBJ_RAW          = 8'h54;

  localparam int PRES_TEMP = 0;
  localparam int PRES_HUMIDITY = 1;
  localparam int PRES_PRESSURE = 2;
  localparam int PRES_BATTERY = 3;
  localparam int PRES_VOLTAGE = 4;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_INVALID   = 2'd1,
    STAT_ENCRYPTED = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       walk;
    status_t    status;
  } queue_entry_t;

  localparam logic [2:0] OBJ_LEN [OBJ_TABLE_SIZE] = '{
    3'd1,3'd1,3'd2,3'd2,3'd3,3'd3,3'd2,3'd2,3'd2,3'd1,3'd3,3'd3,3'd2,3'd2,3'd2,3'd1,
    3'd1,3'd1,3'd2,3'd2,3'd2,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,
    3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,
    3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd1,3'd0,3'd2,3'd2,3'd4,3'd2,
    3'd2,3'd2,3'd3,3'd2,3'd2,3'd2,3'd1,3'd2,3'd2,3'd2,3'd2,3'd3,3'd4,3'd4,3'd4,3'd4,
    3'd4,3'd2,3'd2,3'd0,3'd0,3'd4,3'd2,3'd1,3'd1,3'd1,3'd2,3'd4,3'd4,3'd2,3'd2,3'd2,
    3'd1,3'd2,3'd4,3'd4,3'd1,3'd1
  };

  function automatic logic [2:0] obj_len(input logic [7:0] id);
    logic [2:0] len;
    len = 3'd0;
    if (id < 8'(OBJ_TABLE_SIZE)) begin
      len = OBJ_LEN[id[6:0]];
    end
    return len;
  endfunction

  function automatic logic is_text_obj(input logic [7:0] id);
    return (id == OBJ_TEXT) || (id == OBJ_RAW);
  endfunction

endpackage

@@ design/bthpo_front.sv @@
// Front end: takes bytes, tracks header, address and position, classifies
// each byte and settles the packet status. Depends on bthpo_pkg.
module bthpo_front import bthpo_pkg::*; #(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  output logic         push_valid,
  input  logic         push_ready,
  output queue_entry_t push_entry
);

  logic [7:0] pos;
  status_t    pkt_status;
  logic       addr_present;

  status_t    status_upd;
  status_t    status_final;
  logic       addr_upd;
  logic       in_bounds;
  logic       accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;
  assign in_bounds  = ({8'd0, pos} < 16'(MAX_PACKET_BYTES));

  always_comb begin
    status_upd = pkt_status;
    addr_upd   = addr_present;
    if (in_bounds && (pos == 8'd0)) begin
      if (data_byte[7:5] != HDR_VERSION) begin
        status_upd = STAT_INVALID;
      end else if (data_byte[0]) begin
        status_upd = STAT_ENCRYPTED;
      end else begin
        addr_upd = data_byte[1];
      end
    end
    status_final = status_upd;
    if ((status_upd == STAT_OK) && addr_upd && (pos < ADDR_END_POS)) begin
      status_final = STAT_INVALID;
    end
    if ((status_upd == STAT_ENCRYPTED) && (pos < ENC_MIN_POS)) begin
      status_final = STAT_INVALID;
    end
  end

  always_comb begin
    push_entry.data   = data_byte;
    push_entry.last   = last_byte;
    push_entry.walk   = in_bounds && (pos != 8'd0) && (pkt_status == STAT_OK) &&
                        !(addr_present && (pos <= ADDR_END_POS));
    push_entry.status = status_final;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= 8'd0;
      pkt_status   <= STAT_OK;
      addr_present <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        pos          <= 8'd0;
        pkt_status   <= STAT_OK;
        addr_present <= 1'b0;
      end else begin
        if (pos != POS_MAX) begin
          pos <= pos + 8'd1;
        end
        pkt_status   <= status_upd;
        addr_present <= addr_upd;
      end
    end
  end

endmodule

@@ design/bthpo_queue.sv @@
// Short FIFO of classified bytes between front and back ends.
// Depends on bthpo_pkg.
module bthpo_queue import bthpo_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  queue_entry_t push_entry,
  output logic         pop_valid,
  input  logic         pop_ready,
  output queue_entry_t pop_entry
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic push;
  logic pop;

  assign push_ready = (count != CntW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

@@ design/bthpo_back.sv @@
// Back end: walks objects, decodes values into fixed point registers and
// holds the result register. Depends on bthpo_pkg.
module bthpo_back import bthpo_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  queue_entry_t        pop_entry,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic signed [19:0]  temp_centi_c,
  output logic [15:0]         humidity_centi_pct,
  output logic [23:0]         pressure_centi_hpa,
  output logic [6:0]          battery_pct,
  output logic [15:0]         battery_millivolt,
  output logic signed [1:0]   battery_low_flag,
  output logic [4:0]          present_mask
);

  logic               walk_stopped;
  logic [7:0]         object_code;
  logic [8:0]         bytes_remaining;
  logic [23:0]        value_gather;
  logic signed [19:0] temp_reg;
  logic [15:0]        humidity_reg;
  logic [23:0]        pressure_reg;
  logic [6:0]         battery_reg;
  logic [15:0]        millivolt_reg;
  logic signed [1:0]  low_flag_reg;
  logic [4:0]         presence_bits;

  logic               walk_stopped_next;
  logic [7:0]         object_code_next;
  logic [8:0]         bytes_remaining_next;
  logic [23:0]        value_gather_next;
  logic signed [19:0] temp_reg_next;
  logic [15:0]        humidity_reg_next;
  logic [23:0]        pressure_reg_next;
  logic [6:0]         battery_reg_next;
  logic [15:0]        millivolt_reg_next;
  logic signed [1:0]  low_flag_reg_next;
  logic [4:0]         presence_bits_next;

  logic               pop;
  logic               commit;
  logic [2:0]         len;
  logic [1:0]         idx;
  logic signed [19:0] t_raw;
  logic signed [19:0] t_val;

  assign pop_ready = !out_valid || out_ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    walk_stopped_next    = walk_stopped;
    object_code_next     = object_code;
    bytes_remaining_next = bytes_remaining;
    value_gather_next    = value_gather;
    commit               = 1'b0;
    len                  = obj_len(object_code);
    idx                  = 2'(len - bytes_remaining[2:0]);
    if (pop && pop_entry.walk && !walk_stopped) begin
      if (bytes_remaining == TEXT_LEN_DUE) begin
        bytes_remaining_next = {1'b0, pop_entry.data};
      end else if (bytes_remaining != 9'd0) begin
        bytes_remaining_next = bytes_remaining - 9'd1;
        if (!is_text_obj(object_code)) begin
          case (idx)
            2'd0:    value_gather_next[7:0]   = value_gather[7:0] | pop_entry.data;
            2'd1:    value_gather_next[15:8]  = value_gather[15:8] | pop_entry.data;
            2'd2:    value_gather_next[23:16] = value_gather[23:16] | pop_entry.data;
            default: value_gather_next        = value_gather;
          endcase
          commit = (bytes_remaining == 9'd1);
        end
      end else if (is_text_obj(pop_entry.data)) begin
        object_code_next     = pop_entry.data;
        bytes_remaining_next = TEXT_LEN_DUE;
      end else if (obj_len(pop_entry.data) == 3'd0) begin
        walk_stopped_next = 1'b1;
      end else begin
        object_code_next     = pop_entry.data;
        bytes_remaining_next = {6'd0, obj_len(pop_entry.data)};
        value_gather_next    = '0;
      end
    end
  end

  always_comb begin
    temp_reg_next      = temp_reg;
    humidity_reg_next  = humidity_reg;
    pressure_reg_next  = pressure_reg;
    battery_reg_next   = battery_reg;
    millivolt_reg_next = millivolt_reg;
    low_flag_reg_next  = low_flag_reg;
    presence_bits_next = presence_bits;
    t_raw = 20'(signed'(value_gather_next[15:0]));
    t_val = (object_code == OBJ_TEMP_DECI) ? ((t_raw <<< 3) + (t_raw <<< 1)) : t_raw;
    if (commit) begin
      case (object_code)
        OBJ_BATTERY: begin
          battery_reg_next = (value_gather_next[7:0] > {1'b0, BATTERY_MAX}) ?
                             BATTERY_MAX : value_gather_next[6:0];
          presence_bits_next[PRES_BATTERY] = 1'b1;
        end
        OBJ_TEMP, OBJ_TEMP_DECI: begin
          if (!presence_bits[PRES_TEMP] && !(t_val < ZERO_KELVIN_CENTI)) begin
            temp_reg_next = t_val;
            presence_bits_next[PRES_TEMP] = 1'b1;
          end
        end
        OBJ_HUMIDITY: begin
          humidity_reg_next = value_gather_next[15:0];
          presence_bits_next[PRES_HUMIDITY] = 1'b1;
        end
        OBJ_HUMIDITY_PCT: begin
          humidity_reg_next = 16'(value_gather_next[7:0] * 16'd100);
          presence_bits_next[PRES_HUMIDITY] = 1'b1;
        end
        OBJ_PRESSURE: begin
          pressure_reg_next = value_gather_next;
          presence_bits_next[PRES_PRESSURE] = 1'b1;
        end
        OBJ_VOLTAGE: begin
          millivolt_reg_next = value_gather_next[15:0];
          presence_bits_next[PRES_VOLTAGE] = 1'b1;
        end
        OBJ_LOW_BATT: begin
          low_flag_reg_next = (value_gather_next[7:0] != 8'd0) ? 2'sd1 : 2'sd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_stopped    <= 1'b0;
      object_code     <= 8'd0;
      bytes_remaining <= 9'd0;
      value_gather    <= '0;
      temp_reg        <= '0;
      humidity_reg    <= '0;
      pressure_reg    <= '0;
      battery_reg     <= '0;
      millivolt_reg   <= '0;
      low_flag_reg    <= LOW_FLAG_NONE;
      presence_bits   <= '0;
    end else if (pop) begin
      if (pop_entry.last) begin
        walk_stopped    <= 1'b0;
        object_code     <= 8'd0;
        bytes_remaining <= 9'd0;
        value_gather    <= '0;
        temp_reg        <= '0;
        humidity_reg    <= '0;
        pressure_reg    <= '0;
        battery_reg     <= '0;
        millivolt_reg   <= '0;
        low_flag_reg    <= LOW_FLAG_NONE;
        presence_bits   <= '0;
      end else begin
        walk_stopped    <= walk_stopped_next;
        object_code     <= object_code_next;
        bytes_remaining <= bytes_remaining_next;
        value_gather    <= value_gather_next;
        temp_reg        <= temp_reg_next;
        humidity_reg    <= humidity_reg_next;
        pressure_reg    <= pressure_reg_next;
        battery_reg     <= battery_reg_next;
        millivolt_reg   <= millivolt_reg_next;
        low_flag_reg    <= low_flag_reg_next;
        presence_bits   <= presence_bits_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && pop_entry.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_entry.last) begin
      status <= pop_entry.status;
      if (pop_entry.status == STAT_OK) begin
        temp_centi_c       <= temp_reg_next;
        humidity_centi_pct <= humidity_reg_next;
        pressure_centi_hpa <= pressure_reg_next;
        battery_pct        <= battery_reg_next;
        battery_millivolt  <= millivolt_reg_next;
        battery_low_flag   <= low_flag_reg_next;
        present_mask       <= presence_bits_next;
      end else begin
        temp_centi_c       <= '0;
        humidity_centi_pct <= '0;
        pressure_centi_hpa <= '0;
        battery_pct        <= '0;
        battery_millivolt  <= '0;
        battery_low_flag   <= LOW_FLAG_NONE;
        present_mask       <= '0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_err_clears_values: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STAT_OK) |-> (present_mask == '0) &&
    (battery_low_flag == LOW_FLAG_NONE))
    else $error("error result carries decoded values");

  a_len_due_text: assert property (@(posedge clk) disable iff (rst)
    (bytes_remaining == TEXT_LEN_DUE) |-> is_text_obj(object_code))
    else $error("length byte due for a non-text object");

  a_stop_idle: assert property (@(posedge clk) disable iff (rst)
    walk_stopped |-> (bytes_remaining == 9'd0))
    else $error("walk stopped inside an object");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    pop && pop_entry.last |=> out_valid)
    else $error("last byte gave no result");
`endif

endmodule

@@ design/bthome_v2_object_parser_unit.sv @@
// Top level of the BTHome v2 object parser: front classifier, byte queue
// and object walker. Depends on bthpo_pkg, bthpo_front, bthpo_queue, bthpo_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one service-data byte per
//   transfer, header first, with last_byte set on the final byte.
//   Output channel (out_valid/out_ready) carries one result per packet,
//   produced from the transfer that has last_byte set.
//   Throughput: one byte per cycle, sustained while results are taken,
//   set by the object walker in the back end.
//   Result path: the last byte is registered in the queue; once popped, it
//   loads the result register and sets out_valid.
//   Reset: synchronous, clears packet state, queue and result valid; the
//   first byte after reset is taken as a header.
//   Stall: while a result waits with out_ready low, the back end stops
//   taking bytes; the two-entry queue then fills and in_ready drops.
//   Bytes at positions MAX_PACKET_BYTES and beyond are ignored except for
//   their last_byte flag.
module bthome_v2_object_parser_unit import bthpo_pkg::*; #(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [19:0] temp_centi_c,
  output logic [15:0]        humidity_centi_pct,
  output logic [23:0]        pressure_centi_hpa,
  output logic [6:0]         battery_pct,
  output logic [15:0]        battery_millivolt,
  output logic signed [1:0]  battery_low_flag,
  output logic [4:0]         present_mask
);

  logic         push_valid;
  logic         push_ready;
  queue_entry_t push_entry;
  logic         pop_valid;
  logic         pop_ready;
  queue_entry_t pop_entry;

  bthpo_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  bthpo_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  bthpo_back u_back (
    .clk                (clk),
    .rst                (rst),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .pop_entry          (pop_entry),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .status             (status),
    .temp_centi_c       (temp_centi_c),
    .humidity_centi_pct (humidity_centi_pct),
    .pressure_centi_hpa (pressure_centi_hpa),
    .battery_pct        (battery_pct),
    .battery_millivolt  (battery_millivolt),
    .battery_low_flag   (battery_low_flag),
    .present_mask       (present_mask)
  );

endmodule
